FILE: design/bmfc_pkg.sv
// Shared types and constants for the bank mapper with flash command decoder.
// Holds the beat structs, action and chip select codes and the command bytes.
// No dependencies.
package bmfc_pkg;

    localparam int unsigned LOG_DEPTH      = 10;
    localparam int unsigned STORED_ENTRIES = 6;
    localparam int unsigned SECTOR_BYTES   = 4096;
    localparam int unsigned SECTOR_W       = $clog2(SECTOR_BYTES);

    localparam int unsigned SEQ_W       = 4;
    localparam int unsigned ENTRY_IDX_W = $clog2(STORED_ENTRIES);
    localparam int unsigned OFFSET_W    = 14;
    localparam int unsigned BANK_W      = 5;
    localparam int unsigned TARGET_W    = BANK_W + OFFSET_W;
    localparam int unsigned LOG_ADDR_W  = OFFSET_W + 1;
    localparam int unsigned CMD_LOW_W   = 12;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 5;

    typedef logic [SEQ_W-1:0] seq_count_t;

    // Operation codes of an input beat
    localparam logic OP_LATCH = 1'b0;
    localparam logic OP_FLASH = 1'b1;

    // Command addresses, full (with bank bit 0 on top) and low 12 bits
    localparam logic [LOG_ADDR_W-1:0] CMD_ADDR_HI = 15'h5555;
    localparam logic [LOG_ADDR_W-1:0] CMD_ADDR_LO = 15'h2AAA;
    localparam logic [CMD_LOW_W-1:0]  CMD_LOW_HI  = 12'h555;
    localparam logic [CMD_LOW_W-1:0]  CMD_LOW_LO  = 12'hAAA;

    // Command data bytes
    localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
    localparam logic [7:0] CMD_ID      = 8'h90;
    localparam logic [7:0] CMD_ERASE   = 8'h80;
    localparam logic [7:0] CMD_SECTOR  = 8'h30;
    localparam logic [7:0] CMD_CHIP    = 8'h10;
    localparam logic [7:0] CMD_PROGRAM = 8'hA0;
    localparam logic [7:0] CMD_RESET   = 8'hF0;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_PROGRAM      = 3'd1,
        ACT_ERASE_SECTOR = 3'd2,
        ACT_ERASE_CHIP   = 3'd3,
        ACT_REFUSED      = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        CS_ROM   = 2'd0,
        CS_FLASH = 2'd1,
        CS_ID    = 2'd2
    } chip_sel_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FLASH_ENABLE  = 2'd0,
        REG_MIRROR_STYLE  = 2'd1,
        REG_PRG_BANK_MASK = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                operation;
        logic [OFFSET_W-1:0] cpu_offset;
        logic [7:0]          write_data;
        logic [7:0]          stored_byte;
    } in_item_t;

    typedef struct packed {
        logic [BANK_W-1:0]   prg_bank;
        logic [1:0]          chr_bank;
        logic                mirror_bit;
        chip_sel_t           chip_select;
        action_t             action;
        logic [TARGET_W-1:0] target_offset;
        logic [7:0]          target_data;
    } out_item_t;

    // Control from the top level to the command sequencer
    typedef struct packed {
        logic              flash;
        logic              step;
        logic [7:0]        bank_latch;
        logic [BANK_W-1:0] prg_bank_mask;
    } seq_ctl_t;

    // Decode result of the sequencer for the beat in the input register
    typedef struct packed {
        action_t             action;
        logic [TARGET_W-1:0] target_offset;
        logic [7:0]          target_data;
        logic                id_mode;
    } flash_result_t;

endpackage

FILE: design/bank_mapper_with_flash_commands_core.sv
// Bank mapper with flash command decoder: top level.
// Instantiates bmfc_in_stage and bmfc_flash_seq; depends on bmfc_pkg.
//
// Each s_ beat is one CPU write: a latch write (C000-FFFF) or, with the
// flash handler enabled, a flash command write (8000-BFFF). Every beat gives
// exactly one m_ beat carrying the mapping after the write (PRG bank, CHR
// bank, mirroring bit, chip select) and the flash action it caused.
//
// The accepting edge loads the input register; the decode then moves into the
// result register when that register is free or being drained. Throughput is
// one beat per cycle while the receiver does not stall; the sequence decode is
// a set of parallel compares between the two registers, with the bank
// latch, sequence count and ID mode updated as each beat moves into the
// result register.
//
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more beat; s_ready falls only when both
// are full. The cfg_ port is always ready and must only be written while
// the block is idle. Reset clears the bank latch, the sequence count, ID
// mode and both valid flags, and loads the register reset values.
module bank_mapper_with_flash_commands_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  bmfc_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output bmfc_pkg::out_item_t                   m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bmfc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bmfc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // Configuration registers
    logic                        flash_enable_reg;
    logic [bmfc_pkg::BANK_W-1:0] prg_bank_mask_reg;

    // Mapping state
    logic [7:0] bank_latch_reg;
    logic [7:0] bank_latch_next;

    // Result register
    logic                m_valid_reg;
    logic                m_valid_next;
    bmfc_pkg::out_item_t m_data_reg;
    bmfc_pkg::out_item_t m_data_next;

    logic                    item_valid;
    bmfc_pkg::in_item_t      item;
    logic                    advance;
    logic                    is_flash;
    bmfc_pkg::seq_ctl_t      seq_ctl;
    bmfc_pkg::flash_result_t flash_res;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Move a beat on whenever the result register is free or being drained
    assign advance  = item_valid && (!m_valid_reg || m_ready);
    assign is_flash = (item.operation == bmfc_pkg::OP_FLASH) && flash_enable_reg;

    bmfc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    always_comb begin
        seq_ctl.flash         = is_flash;
        seq_ctl.step          = advance && is_flash;
        seq_ctl.bank_latch    = bank_latch_reg;
        seq_ctl.prg_bank_mask = prg_bank_mask_reg;
    end

    bmfc_flash_seq u_flash_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (seq_ctl),
        .item    (item),
        .res     (flash_res)
    );

    // Latch writes (and every write with flash off) load the bank latch
    assign bank_latch_next = is_flash ? bank_latch_reg : item.write_data;

    always_comb begin
        m_data_next.prg_bank      = bank_latch_next[bmfc_pkg::BANK_W-1:0];
        m_data_next.chr_bank      = bank_latch_next[6:5];
        m_data_next.mirror_bit    = bank_latch_next[7];
        m_data_next.action        = flash_res.action;
        m_data_next.target_offset = flash_res.target_offset;
        m_data_next.target_data   = flash_res.target_data;
        if (!flash_enable_reg) begin
            m_data_next.chip_select = bmfc_pkg::CS_ROM;
        end else if (flash_res.id_mode) begin
            m_data_next.chip_select = bmfc_pkg::CS_ID;
        end else begin
            m_data_next.chip_select = bmfc_pkg::CS_FLASH;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            bank_latch_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                bank_latch_reg <= bank_latch_next;
            end
        end
    end

    // Hold the result until taken; load only on advance
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    // Register writes; the mirroring style only matters to the nametable
    // glue outside this block, so drop it here. Ignore unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_enable_reg  <= 1'b0;
            prg_bank_mask_reg <= '1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bmfc_pkg::REG_FLASH_ENABLE: begin
                    flash_enable_reg <= cfg_data[0];
                end
                bmfc_pkg::REG_PRG_BANK_MASK: begin
                    prg_bank_mask_reg <= cfg_data[bmfc_pkg::BANK_W-1:0];
                end
                default: begin
                    flash_enable_reg <= flash_enable_reg;
                end
            endcase
        end
    end

    a_data_only_program: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.action != bmfc_pkg::ACT_PROGRAM) |-> (m_data.target_data == '0))
        else $error("target data set without a program action");

    a_sector_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.action == bmfc_pkg::ACT_ERASE_SECTOR)
        |-> (m_data.target_offset[bmfc_pkg::SECTOR_W-1:0] == '0))
        else $error("sector erase target not aligned");

    a_rom_no_action: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !flash_enable_reg
        |=> (m_data.chip_select == bmfc_pkg::CS_ROM) && (m_data.action == bmfc_pkg::ACT_NONE))
        else $error("flash activity with the handler disabled");

endmodule

FILE: design/bmfc_in_stage.sv
// Input register of the bank mapper: holds one accepted beat for decode.
// Depends on bmfc_pkg for the input beat struct.
module bmfc_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bmfc_pkg::in_item_t s_data,
    input  logic              take,
    output logic              item_valid,
    output bmfc_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    bmfc_pkg::in_item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload whenever a beat is taken in
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

endmodule

FILE: design/bmfc_flash_seq.sv
// Flash command sequencer: write log, sequence count and ID mode.
// Decodes unlock, ID, erase and program sequences and the reset command. Depends on bmfc_pkg.
module bmfc_flash_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bmfc_pkg::seq_ctl_t      ctl,
    input  bmfc_pkg::in_item_t      item,
    output bmfc_pkg::flash_result_t res
);

    logic [bmfc_pkg::LOG_ADDR_W-1:0] log_addr_reg  [bmfc_pkg::STORED_ENTRIES];
    logic [7:0]                      log_value_reg [bmfc_pkg::STORED_ENTRIES];

    bmfc_pkg::seq_count_t seq_count_reg;
    bmfc_pkg::seq_count_t seq_count_next;
    logic                 id_mode_reg;
    logic                 id_mode_next;

    logic [bmfc_pkg::LOG_ADDR_W-1:0] cur_addr;
    logic [bmfc_pkg::BANK_W-1:0]     bank;
    logic [bmfc_pkg::TARGET_W-1:0]   offset;
    logic [bmfc_pkg::CMD_LOW_W-1:0]  cur_low;
    logic logging;
    logic store_entry;
    logic unlocked;
    logic e2_hi;
    logic e3_unlock1;
    logic e4_unlock2;
    logic cur_hi;
    logic erase_pre;
    logic hit_id;
    logic hit_sector;
    logic hit_chip;
    logic hit_prog;
    logic cmd_addr;
    logic reset_cmd;

    function automatic logic entry_is(
        input logic [bmfc_pkg::LOG_ADDR_W-1:0] addr,
        input logic [7:0]                      value,
        input logic [bmfc_pkg::LOG_ADDR_W-1:0] want_addr,
        input logic [7:0]                      want_value
    );
        return (addr == want_addr) && (value == want_value);
    endfunction

    assign cur_addr = {ctl.bank_latch[0], item.cpu_offset};
    assign bank     = ctl.bank_latch[bmfc_pkg::BANK_W-1:0] & ctl.prg_bank_mask;
    assign offset   = {bank, item.cpu_offset};
    assign cur_low  = item.cpu_offset[bmfc_pkg::CMD_LOW_W-1:0];
    assign cur_hi   = (cur_addr == bmfc_pkg::CMD_ADDR_HI);

    assign logging     = ctl.flash && (seq_count_reg < bmfc_pkg::SEQ_W'(bmfc_pkg::LOG_DEPTH));
    assign store_entry = seq_count_reg < bmfc_pkg::SEQ_W'(bmfc_pkg::STORED_ENTRIES);

    assign unlocked = entry_is(log_addr_reg[0], log_value_reg[0],
                               bmfc_pkg::CMD_ADDR_HI, bmfc_pkg::CMD_UNLOCK1)
                   && entry_is(log_addr_reg[1], log_value_reg[1],
                               bmfc_pkg::CMD_ADDR_LO, bmfc_pkg::CMD_UNLOCK2);
    assign e2_hi      = (log_addr_reg[2] == bmfc_pkg::CMD_ADDR_HI);
    assign e3_unlock1 = entry_is(log_addr_reg[3], log_value_reg[3],
                                 bmfc_pkg::CMD_ADDR_HI, bmfc_pkg::CMD_UNLOCK1);
    assign e4_unlock2 = entry_is(log_addr_reg[4], log_value_reg[4],
                                 bmfc_pkg::CMD_ADDR_LO, bmfc_pkg::CMD_UNLOCK2);

    // The current write is the newest entry of the sequence
    assign hit_id = logging && (seq_count_reg == bmfc_pkg::SEQ_W'(2)) && unlocked
                 && cur_hi && (item.write_data == bmfc_pkg::CMD_ID);

    assign erase_pre = logging && (seq_count_reg == bmfc_pkg::SEQ_W'(5)) && unlocked
                    && e2_hi && (log_value_reg[2] == bmfc_pkg::CMD_ERASE)
                    && e3_unlock1 && e4_unlock2;

    assign hit_sector = erase_pre && (item.write_data == bmfc_pkg::CMD_SECTOR);
    assign hit_chip   = erase_pre && cur_hi && (item.write_data == bmfc_pkg::CMD_CHIP);

    assign hit_prog = logging && (seq_count_reg == bmfc_pkg::SEQ_W'(3)) && unlocked
                   && e2_hi && (log_value_reg[2] == bmfc_pkg::CMD_PROGRAM);

    assign cmd_addr  = (cur_low == bmfc_pkg::CMD_LOW_HI) || (cur_low == bmfc_pkg::CMD_LOW_LO);
    assign reset_cmd = ctl.flash && (item.write_data == bmfc_pkg::CMD_RESET);

    always_comb begin
        res.action        = bmfc_pkg::ACT_NONE;
        res.target_offset = '0;
        res.target_data   = '0;
        res.id_mode       = ctl.step ? id_mode_next : id_mode_reg;
        if (hit_sector) begin
            res.action        = bmfc_pkg::ACT_ERASE_SECTOR;
            res.target_offset = {offset[bmfc_pkg::TARGET_W-1:bmfc_pkg::SECTOR_W],
                                 bmfc_pkg::SECTOR_W'(0)};
        end else if (hit_chip) begin
            res.action = bmfc_pkg::ACT_ERASE_CHIP;
        end else if (hit_prog) begin
            res.target_offset = offset;
            if (item.stored_byte != bmfc_pkg::ERASED_BYTE) begin
                res.action = bmfc_pkg::ACT_REFUSED;
            end else begin
                res.action      = bmfc_pkg::ACT_PROGRAM;
                res.target_data = item.write_data;
            end
        end
    end

    always_comb begin
        seq_count_next = seq_count_reg;
        id_mode_next   = id_mode_reg;
        if (logging) begin
            if (hit_id || hit_sector || hit_chip || hit_prog) begin
                seq_count_next = '0;
            end else begin
                seq_count_next = seq_count_reg + bmfc_pkg::SEQ_W'(1);
            end
        end
        if (hit_id) begin
            id_mode_next = 1'b1;
        end
        // Drop the sequence on a stray address or a reset command
        if (ctl.flash && !cmd_addr) begin
            seq_count_next = '0;
        end
        if (reset_cmd) begin
            seq_count_next = '0;
            id_mode_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_count_reg <= '0;
            id_mode_reg   <= 1'b0;
        end else if (ctl.step) begin
            seq_count_reg <= seq_count_next;
            id_mode_reg   <= id_mode_next;
        end
    end

    // Log the first entries of a sequence; later positions are only counted
    always_ff @(posedge aclk) begin
        if (ctl.step && logging && store_entry) begin
            log_addr_reg[seq_count_reg[bmfc_pkg::ENTRY_IDX_W-1:0]]  <= cur_addr;
            log_value_reg[seq_count_reg[bmfc_pkg::ENTRY_IDX_W-1:0]] <= item.write_data;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_count_reg <= bmfc_pkg::SEQ_W'(bmfc_pkg::LOG_DEPTH))
        else $error("sequence count beyond log depth");

    a_reset_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.step && reset_cmd |=> !id_mode_reg && (seq_count_reg == '0))
        else $error("reset command did not clear the sequence");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for bank_mapper_with_flash_commands_core.
// Directed and random CPU write traffic, checked against a cycle-free
// model of the bank latch and flash command decoder. Depends on bmfc_pkg.
`timescale 1ns / 100ps

module testbench;
    import bmfc_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no beat on any channel
    localparam int unsigned DRAIN_TAIL  = 4;     // margin after the last result beat

    typedef enum logic [1:0] {
        RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE
    } rx_mode_t;

    typedef enum logic [2:0] {
        SEQ_ID, SEQ_PROGRAM, SEQ_SECTOR, SEQ_CHIP, SEQ_RESET
    } flash_seq_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Mapper state as the testbench sees it
    logic [7:0]            map_latch = '0;
    logic [SEQ_W-1:0]      cmd_count = '0;
    logic                  in_id_mode = 1'b0;
    logic [LOG_ADDR_W-1:0] cmd_log_addr [STORED_ENTRIES];
    logic [7:0]            cmd_log_data [STORED_ENTRIES];
    logic                  cfg_flash  = 1'b0;
    logic                  cfg_mirror = 1'b0;
    logic [BANK_W-1:0]     cfg_mask   = 5'd31;

    out_item_t   pending_maps [$];
    int unsigned mismatches      = 0;
    int unsigned writes_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned action_seen [5] = '{default: 0};
    int unsigned burst_left      = 0;
    int unsigned hold_request    = 0;
    int unsigned quiet_cycles    = 0;

    bank_mapper_with_flash_commands_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit log_holds(int unsigned idx, logic [LOG_ADDR_W-1:0] addr,
                                     logic [7:0] value);
        return cmd_log_addr[idx[ENTRY_IDX_W-1:0]] === addr &&
               cmd_log_data[idx[ENTRY_IDX_W-1:0]] === value;
    endfunction

    // Apply one CPU write to the model state and return the mapping it gives
    function automatic out_item_t map_cpu_write(in_item_t w);
        out_item_t           r;
        logic [BANK_W-1:0]   bank;
        logic [TARGET_W-1:0] offset;
        int unsigned         slot;
        r = '0;
        r.action = ACT_NONE;
        if (w.operation == OP_LATCH || !cfg_flash) begin
            map_latch = w.write_data;
        end else begin
            bank   = map_latch[BANK_W-1:0] & cfg_mask;
            offset = {bank, w.cpu_offset};
            // Once the log is full, count nothing and decode nothing
            if (cmd_count < SEQ_W'(LOG_DEPTH)) begin
                slot = 32'(cmd_count);
                if (slot < STORED_ENTRIES) begin
                    cmd_log_addr[slot[ENTRY_IDX_W-1:0]] = {map_latch[0], w.cpu_offset};
                    cmd_log_data[slot[ENTRY_IDX_W-1:0]] = w.write_data;
                end
                cmd_count = cmd_count + SEQ_W'(1);
                if (cmd_count == SEQ_W'(3) && log_holds(0, CMD_ADDR_HI, CMD_UNLOCK1) &&
                    log_holds(1, CMD_ADDR_LO, CMD_UNLOCK2) &&
                    log_holds(2, CMD_ADDR_HI, CMD_ID)) begin
                    in_id_mode = 1'b1;
                    cmd_count  = '0;
                end
                if (cmd_count == SEQ_W'(6) && log_holds(0, CMD_ADDR_HI, CMD_UNLOCK1) &&
                    log_holds(1, CMD_ADDR_LO, CMD_UNLOCK2) &&
                    log_holds(2, CMD_ADDR_HI, CMD_ERASE) &&
                    log_holds(3, CMD_ADDR_HI, CMD_UNLOCK1) &&
                    log_holds(4, CMD_ADDR_LO, CMD_UNLOCK2)) begin
                    if (cmd_log_data[5] == CMD_SECTOR) begin
                        r.action        = ACT_ERASE_SECTOR;
                        r.target_offset = {offset[TARGET_W-1:SECTOR_W], SECTOR_W'(0)};
                        cmd_count       = '0;
                    end else if (log_holds(5, CMD_ADDR_HI, CMD_CHIP)) begin
                        r.action  = ACT_ERASE_CHIP;
                        cmd_count = '0;
                    end
                end
                if (cmd_count == SEQ_W'(4) && log_holds(0, CMD_ADDR_HI, CMD_UNLOCK1) &&
                    log_holds(1, CMD_ADDR_LO, CMD_UNLOCK2) &&
                    log_holds(2, CMD_ADDR_HI, CMD_PROGRAM)) begin
                    r.target_offset = offset;
                    if (w.stored_byte != ERASED_BYTE) begin
                        r.action = ACT_REFUSED;
                    end else begin
                        r.action      = ACT_PROGRAM;
                        r.target_data = w.write_data;
                    end
                    cmd_count = '0;
                end
            end
            if (w.cpu_offset[CMD_LOW_W-1:0] != CMD_LOW_LO &&
                w.cpu_offset[CMD_LOW_W-1:0] != CMD_LOW_HI) begin
                cmd_count = '0;
            end
            if (w.write_data == CMD_RESET) begin
                cmd_count  = '0;
                in_id_mode = 1'b0;
            end
        end
        r.prg_bank    = map_latch[4:0];
        r.chr_bank    = map_latch[6:5];
        r.mirror_bit  = map_latch[7];
        r.chip_select = !cfg_flash ? CS_ROM : (in_id_mode ? CS_ID : CS_FLASH);
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Check every result beat against the oldest outstanding mapping
    always @(posedge aclk) begin : result_check
        out_item_t want;
        out_item_t got;
        if (aresetn && m_valid && m_ready) begin
            got = m_data;
            if (pending_maps.size() == 0) begin
                $error("result beat with nothing expected: 0x%0h", got);
                mismatches++;
            end else begin
                want = pending_maps.pop_front();
                compare_field("prg_bank", want.prg_bank, got.prg_bank);
                compare_field("chr_bank", want.chr_bank, got.chr_bank);
                compare_field("mirror_bit", want.mirror_bit, got.mirror_bit);
                compare_field("chip_select", want.chip_select, got.chip_select);
                compare_field("action", want.action, got.action);
                compare_field("target_offset", want.target_offset, got.target_offset);
                compare_field("target_data", want.target_data, got.target_data);
                action_seen[want.action]++;
                results_checked++;
            end
        end
    end

    // Receiver: a changing stall pattern, plus long hold-offs on request
    initial begin : rx_stall_pattern
        rx_mode_t    mode;
        int unsigned span;
        int unsigned tick;
        int unsigned hold_left;
        mode = RX_OPEN;
        span = 0;
        tick = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(16, 128);
                end
                span--;
                case (mode)
                    RX_OPEN:     m_ready <= 1'b1;
                    RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_ready <= (tick % 4) != 3;
                    default:     m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Give up when no channel has moved a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one CPU write, in bursts with random gaps between them
    task automatic send_write(logic op, logic [OFFSET_W-1:0] off, logic [7:0] data,
                              logic [7:0] stored);
        in_item_t w;
        w.operation   = op;
        w.cpu_offset  = off;
        w.write_data  = data;
        w.stored_byte = stored;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pending_maps.push_back(map_cpu_write(w));
        writes_sent++;
    endtask

    // Flash write to a full 15-bit command address; set latch bit 0 first if needed
    task automatic flash_write_at(logic [LOG_ADDR_W-1:0] addr, logic [7:0] data,
                                  logic [7:0] stored);
        if (map_latch[0] != addr[LOG_ADDR_W-1])
            send_write(OP_LATCH, 14'($urandom), {7'($urandom), addr[LOG_ADDR_W-1]},
                       8'($urandom));
        send_write(OP_FLASH, addr[OFFSET_W-1:0], data, stored);
    endtask

    task automatic unlock(logic [7:0] cmd);
        flash_write_at(CMD_ADDR_HI, CMD_UNLOCK1, 8'($urandom));
        flash_write_at(CMD_ADDR_LO, CMD_UNLOCK2, 8'($urandom));
        flash_write_at(CMD_ADDR_HI, cmd, 8'($urandom));
    endtask

    // Drop valid and hold until every expected result has arrived
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_maps.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FLASH_ENABLE:  cfg_flash  = value[0];
            REG_MIRROR_STYLE:  cfg_mirror = value[0];
            REG_PRG_BANK_MASK: cfg_mask   = value[BANK_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(logic flash, logic mirror, logic [BANK_W-1:0] mask);
        write_reg(REG_FLASH_ENABLE, CFG_DATA_W'(flash));
        write_reg(REG_MIRROR_STYLE, CFG_DATA_W'(mirror));
        write_reg(REG_PRG_BANK_MASK, mask);
    endtask

    // One command sequence with random content, sometimes with a step spoilt
    task automatic run_command_sequence();
        logic [LOG_ADDR_W-1:0] addr [6];
        logic [7:0]            data [6];
        logic [7:0]            stored [6];
        flash_seq_t            kind;
        int unsigned           steps;
        int unsigned           bad;
        for (int i = 0; i < 6; i++) begin
            addr[i]   = 15'($urandom);
            data[i]   = 8'($urandom);
            stored[i] = 8'($urandom);
        end
        addr[0] = CMD_ADDR_HI;
        data[0] = CMD_UNLOCK1;
        addr[1] = CMD_ADDR_LO;
        data[1] = CMD_UNLOCK2;
        addr[2] = CMD_ADDR_HI;
        kind = flash_seq_t'($urandom_range(0, 4));
        case (kind)
            SEQ_ID: begin
                data[2] = CMD_ID;
                steps   = 3;
            end
            SEQ_PROGRAM: begin
                data[2] = CMD_PROGRAM;
                if ($urandom_range(0, 1) != 0)
                    stored[3] = ERASED_BYTE;
                steps = 4;
            end
            SEQ_SECTOR, SEQ_CHIP: begin
                data[2] = CMD_ERASE;
                addr[3] = CMD_ADDR_HI;
                data[3] = CMD_UNLOCK1;
                addr[4] = CMD_ADDR_LO;
                data[4] = CMD_UNLOCK2;
                data[5] = CMD_SECTOR;
                if (kind == SEQ_CHIP) begin
                    addr[5] = CMD_ADDR_HI;
                    data[5] = CMD_CHIP;
                end
                steps = 6;
            end
            default: begin
                addr[0] = 15'($urandom);
                data[0] = CMD_RESET;
                steps   = 1;
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            bad = $urandom_range(0, steps - 1);
            if ($urandom_range(0, 1) != 0)
                data[bad] = 8'($urandom);
            else
                addr[bad] = 15'($urandom);
        end
        for (int i = 0; i < steps; i++)
            flash_write_at(addr[i], data[i], stored[i]);
    endtask

    // A run of writes at command addresses, sometimes long enough to fill the log
    task automatic run_command_noise();
        repeat ($urandom_range(8, 12))
            send_write(OP_FLASH,
                       {2'($urandom), ($urandom_range(0, 1) != 0) ? CMD_LOW_LO : CMD_LOW_HI},
                       8'($urandom), 8'($urandom));
    endtask

    task automatic test_plain_rom();
        // Flash handler off after reset: every write lands in the latch
        send_write(OP_LATCH, 14'h3FFF, 8'hFF, 8'h00);
        send_write(OP_LATCH, 14'h0000, 8'h00, 8'hFF);
        send_write(OP_FLASH, 14'h1555, CMD_UNLOCK1, ERASED_BYTE);
        wait_for_results();
    endtask

    task automatic test_id_mode();
        set_config(1'b1, 1'b0, 5'd31);
        unlock(CMD_ID);
        // Reset command at a plain address leaves ID mode
        send_write(OP_FLASH, 14'h0000, CMD_RESET, 8'h00);
        wait_for_results();
    endtask

    task automatic test_erase();
        unlock(CMD_ERASE);
        flash_write_at(CMD_ADDR_HI, CMD_UNLOCK1, 8'h00);
        flash_write_at(CMD_ADDR_LO, CMD_UNLOCK2, 8'h00);
        flash_write_at(15'h7FFF, CMD_SECTOR, 8'h00);
        unlock(CMD_ERASE);
        flash_write_at(CMD_ADDR_HI, CMD_UNLOCK1, 8'h00);
        flash_write_at(CMD_ADDR_LO, CMD_UNLOCK2, 8'h00);
        flash_write_at(CMD_ADDR_HI, CMD_CHIP, 8'h00);
        wait_for_results();
    endtask

    task automatic test_program();
        set_config(1'b1, 1'b1, 5'h0A);
        unlock(CMD_PROGRAM);
        flash_write_at(15'h0000, 8'h00, ERASED_BYTE);
        // Byte not erased: program refused
        unlock(CMD_PROGRAM);
        flash_write_at(15'h7FFF, 8'hFF, 8'h7F);
        wait_for_results();
    endtask

    task automatic test_log_full();
        // Ten command-address writes fill the log; the next is only ignored
        for (int i = 0; i < 11; i++)
            send_write(OP_FLASH, 14'h0AAA, 8'(i), 8'h00);
        send_write(OP_FLASH, 14'h0123, 8'h11, 8'hFF);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        // Hold the receiver off while the sender keeps offering beats
        hold_request = 64;
        repeat (24)
            send_write(1'($urandom_range(0, 1)), 14'($urandom), 8'($urandom), 8'($urandom));
        wait_for_results();
    endtask

    task automatic test_random_traffic(int unsigned quota);
        int unsigned start;
        int unsigned pick;
        start = writes_sent;
        while (writes_sent - start < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                run_command_sequence();
            else if (pick < 63)
                run_command_noise();
            else if (pick < 85)
                send_write(1'($urandom_range(0, 1)), 14'($urandom), 8'($urandom),
                           8'($urandom));
            else
                send_write(OP_LATCH, 14'($urandom), 8'($urandom), 8'($urandom));
            // Now and then pause until the block has emptied
            if ($urandom_range(0, 199) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_plain_rom();
        test_id_mode();
        test_erase();
        test_program();
        test_log_full();
        test_backpressure();

        set_config(1'b1, 1'b0, 5'd31);
        test_random_traffic(420);
        set_config(1'b1, 1'b1, 5'd0);
        test_random_traffic(420);
        set_config(1'b1, 1'b0, 5'($urandom));
        test_random_traffic(420);
        set_config(1'b0, 1'b1, 5'($urandom));
        test_random_traffic(200);
        set_config(1'b1, 1'b1, 5'h15);
        test_random_traffic(420);

        $display("Covered %0d CPU writes, %0d results checked, under plain ROM, ID mode %s",
                 writes_sent, results_checked, "and several bank masks");
        $display("Flash actions seen: %0d programs, %0d refused, %0d sector, %0d chip erases",
                 action_seen[ACT_PROGRAM], action_seen[ACT_REFUSED],
                 action_seen[ACT_ERASE_SECTOR], action_seen[ACT_ERASE_CHIP]);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
